// ===== src/ws_pkg.sv =====
package ws_pkg;

  // one result item as it sits in the output queue
  typedef struct packed {
    logic [7:0] payload_byte;
    logic [3:0] frame_opcode;
    logic       final_flag;
    logic       error;
    logic       last;
  } result_t;

  // results caused by one accepted byte: a payload item, a status item, or both
  typedef struct packed {
    logic    pay_valid;
    result_t pay;
    logic    stat_valid;
    result_t stat;
  } push_t;

  localparam logic [3:0] OPCODE_CLOSE = 4'd8;
  localparam logic [6:0] LEN_EXT16    = 7'd126;
  localparam logic [6:0] LEN_EXT64    = 7'd127;

  localparam logic [1:0] FORM_SHORT = 2'd0;
  localparam logic [1:0] FORM_16    = 2'd1;
  localparam logic [1:0] FORM_64    = 2'd2;

  localparam logic [3:0] EXT16_BYTES     = 4'd2;
  localparam logic [3:0] EXT64_SKIP      = 4'd4;
  localparam logic [3:0] EXT64_BYTES     = 4'd8;
  localparam logic [3:0] KEY_LEN_BYTES   = 4'd4;

endpackage

// ===== src/ws_parse.sv =====
module ws_parse (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_fire,
  input  logic [7:0]      data_byte,
  input  logic            frame_end,
  output ws_pkg::push_t   push
);

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_SECOND,
    PH_EXT16,
    PH_EXT64,
    PH_KEY,
    PH_PAYLOAD,
    PH_DONE
  } phase_t;

  phase_t      parse_phase, parse_phase_next;
  logic [3:0]  header_byte_count, header_byte_count_next;
  logic [3:0]  opcode_reg, opcode_reg_next;
  logic        fin_reg, fin_reg_next;
  logic        masked_reg, masked_reg_next;
  logic [1:0]  length_form, length_form_next;
  logic [31:0] remaining_length, remaining_length_next;
  logic [31:0] unmask_key, unmask_key_next;
  logic [1:0]  mask_index, mask_index_next;

  always_comb begin
    logic [6:0] code;
    logic [7:0] key_byte;
    logic       length_done;
    logic       err;

    parse_phase_next       = parse_phase;
    header_byte_count_next = header_byte_count;
    opcode_reg_next        = opcode_reg;
    fin_reg_next           = fin_reg;
    masked_reg_next        = masked_reg;
    length_form_next       = length_form;
    remaining_length_next  = remaining_length;
    unmask_key_next        = unmask_key;
    mask_index_next        = mask_index;
    push                   = '0;
    code                   = data_byte[6:0];
    length_done            = 1'b0;
    err                    = 1'b0;

    case (mask_index)
      2'd0:    key_byte = unmask_key[31:24];
      2'd1:    key_byte = unmask_key[23:16];
      2'd2:    key_byte = unmask_key[15:8];
      default: key_byte = unmask_key[7:0];
    endcase

    case (parse_phase)
      PH_FIRST: begin
        fin_reg_next     = data_byte[7];
        opcode_reg_next  = data_byte[3:0];
        parse_phase_next = PH_SECOND;
      end
      PH_SECOND: begin
        masked_reg_next        = data_byte[7];
        remaining_length_next  = '0;
        header_byte_count_next = '0;
        if (code == ws_pkg::LEN_EXT16) begin
          length_form_next = ws_pkg::FORM_16;
          parse_phase_next = PH_EXT16;
        end else if (code == ws_pkg::LEN_EXT64) begin
          length_form_next = ws_pkg::FORM_64;
          parse_phase_next = PH_EXT64;
        end else begin
          length_form_next      = ws_pkg::FORM_SHORT;
          remaining_length_next = {25'd0, code};
          length_done           = 1'b1;
        end
      end
      PH_EXT16: begin
        remaining_length_next  = {remaining_length[23:0], data_byte};
        header_byte_count_next = header_byte_count + 4'd1;
        if (header_byte_count_next >= ws_pkg::EXT16_BYTES) length_done = 1'b1;
      end
      PH_EXT64: begin
        // upper four length bytes are skipped
        if (header_byte_count >= ws_pkg::EXT64_SKIP) begin
          remaining_length_next = {remaining_length[23:0], data_byte};
        end
        header_byte_count_next = header_byte_count + 4'd1;
        if (header_byte_count_next >= ws_pkg::EXT64_BYTES) length_done = 1'b1;
      end
      PH_KEY: begin
        unmask_key_next        = {unmask_key[23:0], data_byte};
        header_byte_count_next = header_byte_count + 4'd1;
        if (header_byte_count_next >= ws_pkg::KEY_LEN_BYTES) begin
          header_byte_count_next = '0;
          mask_index_next        = '0;
          parse_phase_next       = (remaining_length == 32'd0) ? PH_DONE : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        push.pay_valid              = in_fire;
        push.pay.payload_byte       = masked_reg ? (data_byte ^ key_byte) : data_byte;
        push.pay.frame_opcode       = opcode_reg;
        push.pay.final_flag         = fin_reg;
        push.pay.error              = 1'b0;
        push.pay.last               = 1'b0;
        mask_index_next             = mask_index + 2'd1;
        remaining_length_next       = remaining_length - 32'd1;
        if (remaining_length_next == 32'd0) parse_phase_next = PH_DONE;
      end
      default: begin
      end
    endcase

    if (length_done) begin
      header_byte_count_next = '0;
      if (masked_reg_next) begin
        unmask_key_next  = '0;
        parse_phase_next = PH_KEY;
      end else begin
        mask_index_next  = '0;
        parse_phase_next = (remaining_length_next == 32'd0) ? PH_DONE : PH_PAYLOAD;
      end
    end

    if (frame_end) begin
      err                     = (parse_phase_next != PH_DONE);
      push.stat_valid         = in_fire;
      push.stat.payload_byte  = '0;
      push.stat.frame_opcode  = err ? ws_pkg::OPCODE_CLOSE : opcode_reg_next;
      push.stat.final_flag    = fin_reg_next;
      push.stat.error         = err;
      push.stat.last          = 1'b1;
      parse_phase_next        = PH_FIRST;
      header_byte_count_next  = '0;
      opcode_reg_next         = '0;
      fin_reg_next            = 1'b0;
      masked_reg_next         = 1'b0;
      length_form_next        = ws_pkg::FORM_SHORT;
      remaining_length_next   = '0;
      unmask_key_next         = '0;
      mask_index_next         = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase       <= PH_FIRST;
      header_byte_count <= '0;
      opcode_reg        <= '0;
      fin_reg           <= 1'b0;
      masked_reg        <= 1'b0;
      length_form       <= ws_pkg::FORM_SHORT;
      remaining_length  <= '0;
      unmask_key        <= '0;
      mask_index        <= '0;
    end else if (in_fire) begin
      parse_phase       <= parse_phase_next;
      header_byte_count <= header_byte_count_next;
      opcode_reg        <= opcode_reg_next;
      fin_reg           <= fin_reg_next;
      masked_reg        <= masked_reg_next;
      length_form       <= length_form_next;
      remaining_length  <= remaining_length_next;
      unmask_key        <= unmask_key_next;
      mask_index        <= mask_index_next;
    end
  end

endmodule

// ===== src/ws_outq.sv =====
module ws_outq #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  ws_pkg::push_t    push,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output ws_pkg::result_t  head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] ROOM_MAX = CW'(DEPTH - 2);

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == LAST_PTR) ? '0 : p + PW'(1);
  endfunction

  ws_pkg::result_t entries [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic [1:0]      push_n;
  logic            pop;
  ws_pkg::result_t first_item;
  logic [PW-1:0]   wr_ptr_1;

  assign push_n     = {1'b0, push.pay_valid} + {1'b0, push.stat_valid};
  assign first_item = push.pay_valid ? push.pay : push.stat;
  assign wr_ptr_1   = ptr_inc(wr_ptr);
  assign out_valid  = (count != '0);
  assign pop        = out_valid && out_ready;
  assign head       = entries[rd_ptr];
  // room for a payload item and a status item from the same byte
  assign room       = (count <= ROOM_MAX);

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) entries[wr_ptr] <= first_item;
    if (push_n == 2'd2) entries[wr_ptr_1] <= push.stat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      case (push_n)
        2'd1:    wr_ptr <= wr_ptr_1;
        2'd2:    wr_ptr <= ptr_inc(wr_ptr_1);
        default: wr_ptr <= wr_ptr;
      endcase
      if (pop) rd_ptr <= ptr_inc(rd_ptr);
      count <= count + CW'(push_n) - CW'(pop);
    end
  end

endmodule

// ===== src/websocket_frame_parser.sv =====
// websocket frame deframer
//
// input channel: one frame byte per transfer (data_byte), with frame_end set
// on the last byte of the receive buffer. in_valid/in_ready handshake.
// output channel: one result per transfer. payload bytes come out unmasked
// with the header's opcode and fin bit; the byte that carries frame_end adds
// a status result (last = 1, error = 1 and opcode close on a truncated
// buffer). results of a truncated frame already sent are dropped downstream.
//
// a result is registered in the queue as its byte is accepted. throughput:
// one byte per cycle while in_ready is high; the header parser and unmask
// logic sit between the parser state registers and a small result queue of
// DEPTH entries. in_ready is high while the queue has two free slots, so
// with DEPTH >= 4 a receiver that takes a result every cycle never stalls
// the sender. when the receiver stalls, results collect in the queue and
// in_ready drops once fewer than two slots are free; nothing is lost.
// reset (rst, synchronous) returns the parser to the first header byte and
// empties the queue; a new buffer also starts after every status result.
module websocket_frame_parser #(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       frame_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] payload_byte,
  output logic [3:0] frame_opcode,
  output logic       final_flag,
  output logic       error,
  output logic       last
);

  ws_pkg::push_t   push;    // results caused by the accepted byte
  ws_pkg::result_t head;    // oldest result waiting in the queue
  logic            in_fire;

  assign in_fire = in_valid && in_ready;

  // header state machine and payload unmasking
  ws_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .data_byte (data_byte),
    .frame_end (frame_end),
    .push      (push)
  );

  // result queue, takes up to two results per cycle
  ws_outq #(
    .DEPTH (DEPTH)
  ) u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign payload_byte = head.payload_byte;
  assign frame_opcode = head.frame_opcode;
  assign final_flag   = head.final_flag;
  assign error        = head.error;
  assign last         = head.last;

endmodule
